[rtl/vqda_pkg.sv]
// ----------------------------------------------------------------------------
// vqda_pkg
// Shared types and constants of the virtqueue descriptor allocator.
// ----------------------------------------------------------------------------
package vqda_pkg;

  // Queue geometry
  localparam int unsigned DESC_COUNT = 128;
  localparam int unsigned IDX_W      = $clog2(DESC_COUNT);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned AVAIL_W    = 16;
  localparam int unsigned MODE_W     = 2;

  // Stream packing widths
  localparam int unsigned S_DATA_W   = 8;
  localparam int unsigned M_DATA_W   = 40;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_SUBMIT = 2'd2
  } mode_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the item and start the link read
    logic commit;  // apply the operation and load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_sts_t;

endpackage

[rtl/vqda_ctrl.sv]
// ----------------------------------------------------------------------------
// vqda_ctrl
// Two-state sequencer: accept an item, then commit it once the result
// register has room.
// ----------------------------------------------------------------------------
module vqda_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vqda_pkg::dp_sts_t  sts_i,
  output vqda_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Sequence one transaction at a time
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/vqda_dp.sv]
// ----------------------------------------------------------------------------
// vqda_dp
// Datapath: link store with per-entry valid bits, free-list head and count,
// available index and the result register.
// ----------------------------------------------------------------------------
module vqda_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vqda_pkg::ctl_cmd_t                  cmd_i,
  output vqda_pkg::dp_sts_t                   sts_o,
  input  logic [vqda_pkg::MODE_W-1:0]         in_mode_i,
  input  logic [vqda_pkg::IDX_W-1:0]          in_desc_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [vqda_pkg::IDX_W-1:0]          out_granted_o,
  output logic                                out_error_o,
  output logic [vqda_pkg::CNT_W-1:0]          out_free_count_o,
  output logic [vqda_pkg::IDX_W-1:0]          out_ring_slot_o,
  output logic [vqda_pkg::AVAIL_W-1:0]        out_avail_o
);

  localparam int unsigned QS    = vqda_pkg::DESC_COUNT;
  localparam int unsigned IDX_W = vqda_pkg::IDX_W;
  localparam int unsigned CNT_W = vqda_pkg::CNT_W;
  localparam int unsigned AV_W  = vqda_pkg::AVAIL_W;

  // Link store and its valid bits
  logic [CNT_W-1:0] link_mem [QS];
  logic [QS-1:0]    link_vld_q;

  // Captured item
  logic [vqda_pkg::MODE_W-1:0] mode_q;
  logic [IDX_W-1:0]            desc_q;

  // Registered link read
  logic [CNT_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic [CNT_W-1:0] link_val;

  // Allocator state
  logic [CNT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [AV_W-1:0]  avail_q, avail_d;

  // Result register
  logic             out_vld_q;
  logic [IDX_W-1:0] granted_q, granted_d;
  logic             error_q, error_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0] res_count_q;
  logic [AV_W-1:0]  res_avail_q;
  logic             link_we;

  assign sts_o.out_free = !out_vld_q || out_ready_i;

  // Capture the item and read the link at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= in_mode_i;
      desc_q    <= in_desc_i;
      rd_data_q <= link_mem[head_q[IDX_W-1:0]];
      rd_addr_q <= head_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      rd_vld_q <= link_vld_q[head_q[IDX_W-1:0]];
    end
  end

  // An entry never written holds its reset link, index plus one
  assign link_val = rd_vld_q ? rd_data_q : ({1'b0, rd_addr_q} + CNT_W'(1));

  // Apply the operation
  always_comb begin
    head_d    = head_q;
    total_d   = total_q;
    avail_d   = avail_q;
    granted_d = desc_q;
    error_d   = 1'b0;
    slot_d    = '0;
    link_we   = 1'b0;
    case (mode_q)
      vqda_pkg::MODE_ALLOC: begin
        if ((total_q == '0) || (head_q >= CNT_W'(QS))) begin
          error_d   = 1'b1;
          granted_d = '0;
        end else begin
          granted_d = head_q[IDX_W-1:0];
          head_d    = link_val;
          total_d   = total_q - CNT_W'(1);
        end
      end
      vqda_pkg::MODE_FREE: begin
        if (total_q < CNT_W'(QS)) begin
          link_we = 1'b1;
          head_d  = {1'b0, desc_q};
          total_d = total_q + CNT_W'(1);
        end
      end
      vqda_pkg::MODE_SUBMIT: begin
        slot_d  = avail_q[IDX_W-1:0];
        avail_d = avail_q + AV_W'(1);
      end
      default: begin
        granted_d = desc_q;
      end
    endcase
  end

  // Push a freed descriptor into the link store
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && link_we) begin
      link_mem[desc_q] <= head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (cmd_i.commit && link_we) begin
      link_vld_q[desc_q] <= 1'b1;
    end
  end

  // Advance allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      total_q <= CNT_W'(QS);
      avail_q <= '0;
    end else if (cmd_i.commit) begin
      head_q  <= head_d;
      total_q <= total_d;
      avail_q <= avail_d;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      granted_q   <= granted_d;
      error_q     <= error_d;
      slot_q      <= slot_d;
      res_count_q <= total_d;
      res_avail_q <= avail_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_granted_o    = granted_q;
  assign out_error_o      = error_q;
  assign out_free_count_o = res_count_q;
  assign out_ring_slot_o  = slot_q;
  assign out_avail_o      = res_avail_q;

endmodule

[rtl/virtqueue_descriptor_allocator.sv]
// ----------------------------------------------------------------------------
// virtqueue_descriptor_allocator
// Free-list allocator and available-ring index for a split virtqueue.
// ----------------------------------------------------------------------------
// Each accepted transaction runs as an accept step and an execute step: in
// the accept step the link store is read at the current free-list head into
// a register, and in the execute step the operation (allocate, free or
// submit) is applied and the result register loaded; a new item is not
// taken until the last one is committed. A stalled result holds the block in
// its execute step until the result register has room. Out of reset the link
// store needs no clearing pass: a per-entry valid bit makes an entry that was
// never written read as its index plus one, so the block is ready at once.
module virtqueue_descriptor_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] desc_index, [7] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [6:0] granted_index, [14:7] free_count,
                                      // [21:15] ring_slot, [37:22] avail_index,
                                      // [39:38] zero
  output logic [0:0]  m_axis_tuser    // [0] error
);

  vqda_pkg::ctl_cmd_t cmd;
  vqda_pkg::dp_sts_t  sts;

  logic [vqda_pkg::IDX_W-1:0]   granted;
  logic                         error;
  logic [vqda_pkg::CNT_W-1:0]   free_count;
  logic [vqda_pkg::IDX_W-1:0]   ring_slot;
  logic [vqda_pkg::AVAIL_W-1:0] avail;

  vqda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vqda_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_mode_i        (s_axis_tuser),
    .in_desc_i        (s_axis_tdata[vqda_pkg::IDX_W-1:0]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_granted_o    (granted),
    .out_error_o      (error),
    .out_free_count_o (free_count),
    .out_ring_slot_o  (ring_slot),
    .out_avail_o      (avail)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {2'b00, avail, ring_slot, free_count, granted};
  assign m_axis_tuser = error;

endmodule

[dv/vqda_tb_pkg.sv]
// ----------------------------------------------------------------------------
// vqda_tb_pkg
// Reply type and scoreboard for the virtqueue descriptor allocator bench. The
// scoreboard keeps its own free list and available index, works out the reply
// of every accepted operation and checks replies in order of arrival.
// ----------------------------------------------------------------------------
package vqda_tb_pkg;

  import vqda_pkg::*;

  // Mode value that the allocator has no operation for
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Mismatches beyond this count are only counted
  localparam int unsigned REPORT_LIMIT = 10;

  // One reply of the allocator, field by field
  typedef struct packed {
    logic [IDX_W-1:0]   granted_index;
    logic               error;
    logic [CNT_W-1:0]   free_count;
    logic [IDX_W-1:0]   ring_slot;
    logic [AVAIL_W-1:0] avail_index;
  } alloc_reply_t;

  class alloc_scoreboard;

    // Shadow free list: link store, head, free count and available index
    logic [CNT_W-1:0]   next_link [DESC_COUNT];
    logic [CNT_W-1:0]   head_idx;
    logic [CNT_W-1:0]   free_left;
    logic [AVAIL_W-1:0] avail_ctr;

    alloc_reply_t pending_replies [$];
    int unsigned  mismatches;

    // Start from the reset list: entry i links to i + 1, all entries free
    function new();
      for (int i = 0; i < DESC_COUNT; i++) begin
        next_link[i] = CNT_W'(i + 1);
      end
      head_idx   = '0;
      free_left  = CNT_W'(DESC_COUNT);
      avail_ctr  = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted operation to the shadow state and queue its reply
    function alloc_reply_t apply_operation(input logic [MODE_W-1:0] mode,
                                           input logic [IDX_W-1:0]  desc);
      alloc_reply_t r;
      r.granted_index = desc;
      r.error         = 1'b0;
      r.ring_slot     = '0;
      case (mode)
        MODE_ALLOC: begin
          // Empty list when nothing is free or the head runs off the table
          if (free_left == 0 || head_idx >= DESC_COUNT) begin
            r.error         = 1'b1;
            r.granted_index = '0;
          end else begin
            r.granted_index = head_idx[IDX_W-1:0];
            head_idx        = next_link[head_idx[IDX_W-1:0]];
            free_left       = free_left - 1'b1;
          end
        end
        MODE_FREE: begin
          // Push as new head unless the list is already full; no double-free check
          if (free_left < DESC_COUNT) begin
            next_link[desc] = head_idx;
            head_idx        = {1'b0, desc};
            free_left       = free_left + 1'b1;
          end
        end
        MODE_SUBMIT: begin
          // Slot is the index before the increment, modulo the queue size
          r.ring_slot = avail_ctr[IDX_W-1:0];
          avail_ctr   = avail_ctr + 1'b1;
        end
        default: begin
        end
      endcase
      r.free_count  = free_left;
      r.avail_index = avail_ctr;
      pending_replies.push_back(r);
      return r;
    endfunction

    // Compare one reply against the oldest queued reply
    function void check_reply(input alloc_reply_t got);
      alloc_reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected reply: granted %0d err %0d free %0d slot %0d avail %0d",
                   got.granted_index, got.error, got.free_count, got.ring_slot,
                   got.avail_index);
        end
        return;
      end
      want = pending_replies.pop_front();
      if (got.granted_index !== want.granted_index || got.error !== want.error ||
          got.free_count !== want.free_count || got.ring_slot !== want.ring_slot ||
          got.avail_index !== want.avail_index) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("reply mismatch: granted %0d/%0d err %0d/%0d free %0d/%0d",
                   want.granted_index, got.granted_index, want.error, got.error,
                   want.free_count, got.free_count);
          $display("  slot %0d/%0d avail %0d/%0d (expected/actual)",
                   want.ring_slot, got.ring_slot, want.avail_index, got.avail_index);
        end
      end
    endfunction

  endclass

endpackage

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the virtqueue descriptor allocator.
// ----------------------------------------------------------------------------
// A directed opening covers frees on a full list, allocates, submits with edge
// descriptor numbers, the unused mode and a double free. Random traffic then
// runs in phases that drain the list to empty, refill it past full and mix all
// operations; most frees return descriptors handed out earlier. Both sides
// idle at random, and the receiver holds off once for a long stretch so the
// block backs up. Each reply is checked against the scoreboard.
module tb_top;

  import vqda_pkg::*;
  import vqda_tb_pkg::*;

  localparam int unsigned RANDOM_OPS      = 1030;
  localparam int unsigned PHASE_LEN       = 200;
  localparam int unsigned IDLE_SPAN       = 64;
  localparam int unsigned MAX_GAP         = 10;
  localparam int unsigned HOLD_OFF_AT     = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  typedef enum {PH_DRAIN, PH_FILL, PH_MIXED} traffic_phase_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;   // [6:0] desc_index, [7] zero
  logic [MODE_W-1:0] s_axis_tuser;   // [1:0] mode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [39:0]       m_axis_tdata;   // [6:0] granted_index, [14:7] free_count,
                                     // [21:15] ring_slot, [37:22] avail_index
  logic [0:0]        m_axis_tuser;   // [0] error

  alloc_scoreboard  board = new();
  logic [IDX_W-1:0] handed_out [$];
  bit               send_idle_en;
  bit               recv_idle_en;
  int unsigned      cycle_cnt = 0;

  virtqueue_descriptor_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one operation after a random gap and hold it until the transaction;
  // called and returning at a falling edge
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] desc);
    int unsigned  gap;
    alloc_reply_t r;
    gap = send_idle_en ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, desc};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = board.apply_operation(mode, desc);
    if (mode == MODE_ALLOC && !r.error) begin
      handed_out.push_back(r.granted_index);
    end
    @(negedge clk_i);
  endtask

  // Draw one random operation weighted by the traffic phase
  task automatic send_random_op(input traffic_phase_e phase);
    int unsigned      roll;
    int unsigned      pick;
    int unsigned      alloc_pct;
    int unsigned      free_pct;
    logic [IDX_W-1:0] desc;
    roll = $urandom_range(99, 0);
    desc = IDX_W'($urandom_range(DESC_COUNT - 1, 0));
    case (phase)
      PH_DRAIN: begin alloc_pct = 85; free_pct = 90; end
      PH_FILL:  begin alloc_pct = 10; free_pct = 85; end
      default:  begin alloc_pct = 35; free_pct = 70; end
    endcase
    if (roll < alloc_pct) begin
      send_op(MODE_ALLOC, desc);
    end else if (roll < free_pct) begin
      // Mostly return a descriptor that was handed out, else a random one
      if (handed_out.size() != 0 && $urandom_range(4, 0) != 0) begin
        pick = $urandom_range(handed_out.size() - 1, 0);
        desc = handed_out[pick];
        handed_out.delete(pick);
      end
      send_op(MODE_FREE, desc);
    end else if (roll < 96) begin
      send_op(MODE_SUBMIT, desc);
    end else begin
      send_op(MODE_UNUSED, desc);
    end
  endtask

  // Reset, directed opening, random phases, then drain and judge
  initial begin
    traffic_phase_e phase;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    send_idle_en  = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Frees on a full list are dropped
    send_op(MODE_FREE, 7'd5);
    send_op(MODE_FREE, 7'd127);
    // Allocate ignores the descriptor field
    send_op(MODE_ALLOC, 7'd127);
    send_op(MODE_ALLOC, 7'd0);
    send_op(MODE_ALLOC, 7'h55);
    // Submit with edge and alternating descriptor numbers
    send_op(MODE_SUBMIT, 7'd0);
    send_op(MODE_SUBMIT, 7'd127);
    send_op(MODE_SUBMIT, 7'h55);
    send_op(MODE_SUBMIT, 7'h2A);
    // Unused mode changes nothing
    send_op(MODE_UNUSED, 7'd127);
    send_op(MODE_UNUSED, 7'h2A);
    // Double free, then pop the repeated entry
    send_op(MODE_FREE, 7'd1);
    send_op(MODE_FREE, 7'd1);
    send_op(MODE_ALLOC, 7'd0);
    send_op(MODE_ALLOC, 7'd0);
    send_op(MODE_ALLOC, 7'd0);
    // Return the top descriptor and take it again
    send_op(MODE_FREE, 7'd127);
    send_op(MODE_ALLOC, 7'd0);
    send_op(MODE_FREE, 7'd0);
    send_op(MODE_SUBMIT, 7'd1);

    // Drain first, then refill, then random phases
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % PHASE_LEN == 0) begin
        if (n == 0) begin
          phase = PH_DRAIN;
        end else if (n == PHASE_LEN) begin
          phase = PH_FILL;
        end else begin
          phase = traffic_phase_e'($urandom_range(2, 0));
        end
      end
      if (n % IDLE_SPAN == 0) begin
        send_idle_en = ($urandom_range(3, 0) != 0);
      end
      send_random_op(phase);
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Take replies with random stalls and one long hold-off
  initial begin
    int unsigned  replies_seen;
    int unsigned  stall;
    alloc_reply_t got;
    m_axis_tready = 1'b0;
    replies_seen  = 0;
    recv_idle_en  = 1'b1;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (replies_seen % IDLE_SPAN == 0) begin
        recv_idle_en = ($urandom_range(3, 0) != 0);
      end
      if (replies_seen == HOLD_OFF_AT) begin
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = recv_idle_en ? $urandom_range(MAX_GAP, 0) : 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.granted_index = m_axis_tdata[6:0];
      got.free_count    = m_axis_tdata[14:7];
      got.ring_slot     = m_axis_tdata[21:15];
      got.avail_index   = m_axis_tdata[37:22];
      got.error         = m_axis_tuser[0];
      board.check_reply(got);
      replies_seen++;
      @(negedge clk_i);
    end
  end

endmodule
